FILE: rtl/coht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coht_pkg: shared types and constants for the chained hash table
// Request and response payloads, operation and status codes, controller
// state and step codes, and the fixed widths of the record fields.
// ----------------------------------------------------------------------------
package coht_pkg;

	// Fixed field widths
	localparam int KEY_W    = 31;
	localparam int PAY_W    = 64;
	localparam int DIGIT_W  = 4;
	localparam int TERM_MAX = 90;

	// Default geometry
	localparam int BLOCK_COUNT_DEF = 64;
	localparam int BUCKETS_DEF     = 7;

	// floor(k / 10) = (k * RECIP10) >> RECIP_SHIFT, exact for k below 2^32
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef enum logic [1:0] {
		OP_FIND    = 2'd0,
		OP_INSERT  = 2'd1,
		OP_DELETE  = 2'd2,
		OP_REPLACE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_DUP  = 2'd2,
		STAT_FULL = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_HASH,
		ST_HEAD,
		ST_WALK,
		ST_ACT,
		ST_RD,
		ST_WR,
		ST_OUT
	} state_t;

	// Read-modify-write steps of insert, delete and replace
	typedef enum logic [3:0] {
		STEP_INS_E0,
		STEP_INS_FRESH,
		STEP_INS_A0,
		STEP_INS_AFTER,
		STEP_INS_POS,
		STEP_INS_NEW,
		STEP_DEL_P,
		STEP_DEL_N,
		STEP_DEL_E0,
		STEP_DEL_F,
		STEP_DEL_ANC,
		STEP_DEL_POS,
		STEP_REP
	} step_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PAY_W-1:0] payload_out;
		logic [5:0]       position;
		logic [2:0]       bucket;
	} rsp_t;

endpackage

FILE: rtl/coht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coht_ram: block store
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module coht_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/coht_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coht_fold: digit folding hash
// Peels one decimal digit per cycle, weights it by its place in the pair
// pattern and keeps the running sum reduced modulo BUCKETS.
// ----------------------------------------------------------------------------
module coht_fold import coht_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output logic             done,
	output logic [BKT_W-1:0] bucket
);

	// v mod BUCKETS for every weighted digit value
	function automatic logic [(TERM_MAX+1)*BKT_W-1:0] build_mod_tab();
		logic [(TERM_MAX+1)*BKT_W-1:0] t;
		t = '0;
		for (int i = 0; i <= TERM_MAX; i++) begin
			t[i*BKT_W +: BKT_W] = BKT_W'(i % BUCKETS);
		end
		return t;
	endfunction

	localparam logic [(TERM_MAX+1)*BKT_W-1:0] MOD_TAB = build_mod_tab();
	localparam logic [BKT_W-1:0] ONE_MOD = BKT_W'(1 % BUCKETS);

	logic             busy_q;
	logic             done_q;
	logic [KEY_W-1:0] k_q;
	logic [1:0]       place_q;
	logic [BKT_W-1:0] acc_q;

	logic [63:0]      prod;
	logic [KEY_W-1:0] quo;
	logic [KEY_W-1:0] quo10;
	logic [DIGIT_W-1:0] digit;
	logic [6:0]       term;
	logic [BKT_W:0]   acc_sum;
	logic [BKT_W-1:0] acc_n;

	// one digit: quotient by reciprocal, remainder by shift-add
	always_comb begin
		prod  = 64'(k_q) * 64'(RECIP10);
		quo   = KEY_W'(prod >> RECIP_SHIFT);
		quo10 = (quo << 3) + (quo << 1);
		digit = DIGIT_W'(k_q - quo10);
		// second and third digit of every four carry the tens weight
		if (place_q == 2'd1 || place_q == 2'd2) begin
			term = (7'(digit) << 3) + (7'(digit) << 1);
		end else begin
			term = 7'(digit);
		end
		acc_sum = (BKT_W+1)'(acc_q) + (BKT_W+1)'(MOD_TAB[int'(term)*BKT_W +: BKT_W]);
		if (acc_sum >= (BKT_W+1)'(BUCKETS)) begin
			acc_n = BKT_W'(acc_sum - (BKT_W+1)'(BUCKETS));
		end else begin
			acc_n = BKT_W'(acc_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && k_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q     <= key;
			place_q <= 2'd0;
			acc_q   <= ONE_MOD;
		end else if (busy_q && k_q != '0) begin
			k_q     <= quo;
			place_q <= place_q + 2'd1;
			acc_q   <= acc_n;
		end
	end

	assign done   = done_q;
	assign bucket = acc_q;

endmodule

FILE: rtl/chained_overflow_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_overflow_hash_table: hash table with chained buckets and free list
//
// One request (find, insert, delete, replace) enters on req_valid/req_ready
// and gives exactly one response on rsp_valid/rsp_ready. Requests are taken
// one at a time: req_ready is high only while the controller is idle.
// The fold unit hashes the key one decimal digit per cycle. The chain walk
// then visits one block per cycle on the store's single read port, at
// most BLOCK_COUNT blocks, and the request ends with its read-modify-write
// steps on the store (none for find, up to 6 for insert or delete).
// After reset the store is loaded with its initial chains and req_ready
// stays low meanwhile. The response sits in an output
// register: the next request is accepted while it waits, and a finished
// request only holds in its last state while the receiver stalls with the
// previous response still pending.
// ----------------------------------------------------------------------------
module chained_overflow_hash_table import coht_pkg::*; #(
	parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
	parameter int BUCKETS     = BUCKETS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int ADDR_W = $clog2(BLOCK_COUNT);
	localparam int LINK_W = ADDR_W + 1;
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CMP_W  = (BKT_W + 1 > LINK_W) ? BKT_W + 1 : LINK_W;
	localparam int ENT_W  = 1 + KEY_W + PAY_W + 2 * LINK_W;

	// entry layout: {active, key, payload, next, prev}
	localparam int NEXT_LSB = LINK_W;
	localparam int PAY_LSB  = 2 * LINK_W;
	localparam int KEY_LSB  = PAY_LSB + PAY_W;
	localparam int ACT_BIT  = KEY_LSB + KEY_W;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(BLOCK_COUNT);
	localparam logic [LINK_W-1:0] ANCHOR_INIT =
		(BUCKETS + 1 < BLOCK_COUNT) ? LINK_W'(BUCKETS + 1) : LINK_W'(BLOCK_COUNT);

	state_t state_q, state_d;
	step_t  step_q, step_d;

	req_t              req_q, req_d;
	logic [BKT_W-1:0]  bkt_q, bkt_d;
	logic              head_ok_q, head_ok_d;
	logic              found_q, found_d;
	logic [LINK_W-1:0] cur_q, cur_d;
	logic [LINK_W-1:0] steps_q, steps_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [PAY_W-1:0]  ent_pay_q, ent_pay_d;
	logic [LINK_W-1:0] ent_next_q, ent_next_d;
	logic [LINK_W-1:0] ent_prev_q, ent_prev_d;
	logic [LINK_W-1:0] fresh_q, fresh_d;
	logic [LINK_W-1:0] after_q, after_d;
	logic [LINK_W-1:0] pred_q, pred_d;
	stat_t             res_status_q, res_status_d;
	logic [PAY_W-1:0]  res_pay_q, res_pay_d;
	logic [LINK_W-1:0] init_q, init_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              rsp_load;

	logic              fold_start;
	logic              fold_done;
	logic [BKT_W-1:0]  fold_bkt;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ENT_W-1:0]  rd_data;

	logic              rd_act;
	logic [KEY_W-1:0]  rd_key;
	logic [PAY_W-1:0]  rd_pay;
	logic [LINK_W-1:0] rd_next;
	logic [LINK_W-1:0] rd_prev;

	logic              w_act;
	logic [KEY_W-1:0]  w_key;
	logic [PAY_W-1:0]  w_pay;
	logic [LINK_W-1:0] w_next;
	logic [LINK_W-1:0] w_prev;

	logic [CMP_W-1:0]  head;
	logic              head_in;
	logic [LINK_W-1:0] steps_n;
	logic [LINK_W-1:0] step_addr;
	logic              step_en;
	logic              step_ro;
	logic              step_last;
	step_t             step_next;
	logic [CMP_W-1:0]  init_cmp;

	// Units
	coht_fold #(
		.BUCKETS (BUCKETS),
		.BKT_W   (BKT_W)
	) u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fold_start),
		.key    (req_d.key),
		.done   (fold_done),
		.bucket (fold_bkt)
	);

	coht_ram #(
		.DEPTH (BLOCK_COUNT),
		.WIDTH (ENT_W),
		.AW    (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Entry fields
	assign rd_act  = rd_data[ACT_BIT];
	assign rd_key  = rd_data[KEY_LSB +: KEY_W];
	assign rd_pay  = rd_data[PAY_LSB +: PAY_W];
	assign rd_next = rd_data[NEXT_LSB +: LINK_W];
	assign rd_prev = rd_data[0 +: LINK_W];

	assign head     = CMP_W'(bkt_q) + CMP_W'(1);
	assign head_in  = head < CMP_W'(BLOCK_COUNT);
	assign steps_n  = steps_q + LINK_W'(1);
	assign init_cmp = CMP_W'(init_q);

	// Step table: target block, skip rule, read-only flag and successor
	always_comb begin
		step_addr = LINK_W'(0);
		step_en   = 1'b1;
		step_ro   = 1'b0;
		step_last = 1'b0;
		step_next = step_q;
		case (step_q)
			STEP_INS_E0: begin
				step_ro   = 1'b1;
				step_next = STEP_INS_FRESH;
			end
			STEP_INS_FRESH: begin
				step_addr = fresh_q;
				step_ro   = 1'b1;
				step_next = STEP_INS_A0;
			end
			STEP_INS_A0: begin
				step_next = STEP_INS_AFTER;
			end
			STEP_INS_AFTER: begin
				step_addr = after_q;
				step_en   = after_q != NIL;
				step_next = STEP_INS_POS;
			end
			STEP_INS_POS: begin
				step_addr = LINK_W'(pos_q);
				step_next = STEP_INS_NEW;
			end
			STEP_INS_NEW: begin
				step_addr = fresh_q;
				step_last = 1'b1;
			end
			STEP_DEL_P: begin
				step_addr = pred_q;
				step_en   = pred_q < NIL;
				step_next = STEP_DEL_N;
			end
			STEP_DEL_N: begin
				step_addr = after_q;
				step_en   = after_q != NIL;
				step_next = STEP_DEL_E0;
			end
			STEP_DEL_E0: begin
				step_ro   = 1'b1;
				step_next = STEP_DEL_F;
			end
			STEP_DEL_F: begin
				step_addr = fresh_q;
				step_en   = fresh_q != NIL;
				step_next = STEP_DEL_ANC;
			end
			STEP_DEL_ANC: begin
				step_next = STEP_DEL_POS;
			end
			STEP_DEL_POS: begin
				step_addr = LINK_W'(pos_q);
				step_last = 1'b1;
			end
			STEP_REP: begin
				step_addr = LINK_W'(pos_q);
				step_last = 1'b1;
			end
			default: begin
				step_last = 1'b1;
			end
		endcase
	end

	// Controller: next state, store accesses and datapath updates
	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		req_d        = req_q;
		bkt_d        = bkt_q;
		head_ok_d    = head_ok_q;
		found_d      = found_q;
		cur_d        = cur_q;
		steps_d      = steps_q;
		pos_d        = pos_q;
		ent_pay_d    = ent_pay_q;
		ent_next_d   = ent_next_q;
		ent_prev_d   = ent_prev_q;
		fresh_d      = fresh_q;
		after_d      = after_q;
		pred_d       = pred_q;
		res_status_d = res_status_q;
		res_pay_d    = res_pay_q;
		init_d       = init_q;
		req_ready    = 1'b0;
		fold_start   = 1'b0;
		rsp_load     = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		w_act        = rd_act;
		w_key        = rd_key;
		w_pay        = rd_pay;
		w_next       = rd_next;
		w_prev       = rd_prev;

		case (state_q)
			// load the initial chains, one block per cycle
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = init_q[ADDR_W-1:0];
				w_act   = 1'b0;
				w_key   = '0;
				w_pay   = '0;
				if (init_q == '0) begin
					w_next = ANCHOR_INIT;
					w_prev = NIL;
				end else if (init_cmp <= CMP_W'(BUCKETS)) begin
					w_next = NIL;
					w_prev = NIL;
				end else begin
					w_next = (init_q + LINK_W'(1) < NIL) ? init_q + LINK_W'(1) : NIL;
					w_prev = (init_cmp == CMP_W'(BUCKETS + 1)) ? LINK_W'(0)
					                                          : init_q - LINK_W'(1);
				end
				init_d = init_q + LINK_W'(1);
				if (init_q == LINK_W'(BLOCK_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					req_d      = req;
					fold_start = 1'b1;
					state_d    = ST_HASH;
				end
			end
			ST_HASH: begin
				if (fold_done) begin
					bkt_d   = fold_bkt;
					state_d = ST_HEAD;
				end
			end
			// start the chain walk at the bucket's head block
			ST_HEAD: begin
				found_d   = 1'b0;
				pos_d     = '0;
				head_ok_d = head_in;
				ent_pay_d = '0;
				if (head_in) begin
					rd_en   = 1'b1;
					rd_addr = head[ADDR_W-1:0];
					cur_d   = LINK_W'(head);
					steps_d = '0;
					state_d = ST_WALK;
				end else begin
					state_d = ST_ACT;
				end
			end
			// one chain block per cycle
			ST_WALK: begin
				pos_d      = cur_q[ADDR_W-1:0];
				ent_pay_d  = rd_pay;
				ent_next_d = rd_next;
				ent_prev_d = rd_prev;
				if (rd_act && rd_key == req_q.key) begin
					found_d = 1'b1;
					state_d = ST_ACT;
				end else if (steps_n == LINK_W'(BLOCK_COUNT) || rd_next >= NIL) begin
					state_d = ST_ACT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_next[ADDR_W-1:0];
					cur_d   = rd_next;
					steps_d = steps_n;
				end
			end
			ST_ACT: begin
				res_status_d = STAT_MISS;
				res_pay_d    = '0;
				state_d      = ST_OUT;
				case (req_q.operation)
					OP_FIND: begin
						if (found_q) begin
							res_status_d = STAT_OK;
							res_pay_d    = ent_pay_q;
						end
					end
					OP_INSERT: begin
						if (found_q) begin
							res_status_d = STAT_DUP;
							res_pay_d    = ent_pay_q;
						end else if (!head_ok_q) begin
							res_status_d = STAT_FULL;
						end else begin
							step_d  = STEP_INS_E0;
							state_d = ST_RD;
						end
					end
					OP_DELETE: begin
						if (found_q) begin
							res_status_d = STAT_OK;
							res_pay_d    = ent_pay_q;
							pred_d       = ent_prev_q;
							after_d      = (ent_next_q >= NIL) ? NIL : ent_next_q;
							step_d       = STEP_DEL_P;
							state_d      = ST_RD;
						end
					end
					OP_REPLACE: begin
						if (found_q) begin
							res_status_d = STAT_OK;
							res_pay_d    = req_q.payload;
							step_d       = STEP_REP;
							state_d      = ST_RD;
						end
					end
					default: begin
						state_d = ST_OUT;
					end
				endcase
			end
			// read half of a step, or skip it
			ST_RD: begin
				if (step_en) begin
					rd_en   = 1'b1;
					rd_addr = step_addr[ADDR_W-1:0];
					state_d = ST_WR;
				end else if (step_last) begin
					state_d = ST_OUT;
				end else begin
					step_d = step_next;
				end
			end
			// modify and write back; read-only steps only capture the block
			ST_WR: begin
				wr_en   = !step_ro;
				wr_addr = step_addr[ADDR_W-1:0];
				if (step_last) begin
					state_d = ST_OUT;
				end else begin
					step_d  = step_next;
					state_d = ST_RD;
				end
				case (step_q)
					STEP_INS_E0: begin
						if (rd_next == '0 || rd_next >= NIL) begin
							res_status_d = STAT_FULL;
							state_d      = ST_OUT;
						end else begin
							fresh_d = rd_next;
						end
					end
					STEP_INS_FRESH: begin
						after_d = (rd_next >= NIL) ? NIL : rd_next;
					end
					STEP_INS_A0: begin
						w_next = after_q;
					end
					STEP_INS_AFTER: begin
						w_prev = '0;
					end
					STEP_INS_POS: begin
						w_next = fresh_q;
					end
					STEP_INS_NEW: begin
						w_prev       = LINK_W'(pos_q);
						w_next       = NIL;
						w_key        = req_q.key;
						w_pay        = req_q.payload;
						w_act        = 1'b1;
						pos_d        = fresh_q[ADDR_W-1:0];
						res_status_d = STAT_OK;
						res_pay_d    = req_q.payload;
					end
					STEP_DEL_P: begin
						w_next = after_q;
					end
					STEP_DEL_N: begin
						w_prev = pred_q;
					end
					STEP_DEL_E0: begin
						fresh_d = (rd_next >= NIL) ? NIL : rd_next;
					end
					STEP_DEL_F: begin
						w_prev = LINK_W'(pos_q);
					end
					STEP_DEL_ANC: begin
						w_next = LINK_W'(pos_q);
					end
					STEP_DEL_POS: begin
						w_next = fresh_q;
						w_prev = '0;
						w_act  = 1'b0;
					end
					STEP_REP: begin
						w_pay = req_q.payload;
					end
					default: begin
						w_act = rd_act;
					end
				endcase
			end
			// hand the response to the output register
			ST_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign wr_data = {w_act, w_key, w_pay, w_next, w_prev};

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			step_q      <= STEP_INS_E0;
			init_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			init_q  <= init_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		req_q        <= req_d;
		bkt_q        <= bkt_d;
		head_ok_q    <= head_ok_d;
		found_q      <= found_d;
		cur_q        <= cur_d;
		steps_q      <= steps_d;
		pos_q        <= pos_d;
		ent_pay_q    <= ent_pay_d;
		ent_next_q   <= ent_next_d;
		ent_prev_q   <= ent_prev_d;
		fresh_q      <= fresh_d;
		after_q      <= after_d;
		pred_q       <= pred_d;
		res_status_q <= res_status_d;
		res_pay_q    <= res_pay_d;
		if (rsp_load) begin
			rsp_q.status      <= res_status_q;
			rsp_q.payload_out <= res_pay_q;
			rsp_q.position    <= 6'(pos_q);
			rsp_q.bucket      <= 3'(bkt_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("store written while idle");

	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == ST_HASH)
		else $error("accepted request did not start hashing");

	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("response raised outside the output state");

	a_no_read_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("store read and written in the same cycle");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for chained_overflow_hash_table
// Random find/insert/delete/replace requests over a small key pool that
// collides heavily in the seven buckets, filling the store to full and
// then deleting every second fill key. A behavioral copy of the chained
// block store predicts each response; the monitor compares them in order.
// ----------------------------------------------------------------------------
module tb;
	import coht_pkg::*;

	localparam int NBLK = 64;
	localparam int NBKT = 7;
	localparam int NIL  = NBLK;
	localparam int CYCLE_LIMIT = 800000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	chained_overflow_hash_table uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// Shadow copy of the block store
	logic [KEY_W-1:0] sh_key [NBLK];
	logic [PAY_W-1:0] sh_pay [NBLK];
	logic             sh_act [NBLK];
	int               sh_next [NBLK];
	int               sh_prev [NBLK];

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   n_err;
	int   cycles;
	bit   stim_done;
	logic [KEY_W-1:0] key_pool [24];

	function automatic int digit_fold_bucket(logic [KEY_W-1:0] key);
		int unsigned k, lo, hi, sum, pair;
		k = key; sum = 0; pair = 1;
		forever begin
			lo = k % 10; k = k / 10;
			hi = k % 10; k = k / 10;
			if (pair[0]) sum += hi * 10 + lo;
			else sum += lo * 10 + hi;
			pair++;
			if (k == 0) break;
		end
		return (sum + 1) % NBKT;
	endfunction

	function automatic void reset_store();
		for (int i = 0; i < NBLK; i++) begin
			sh_key[i] = '0; sh_pay[i] = '0; sh_act[i] = 1'b0;
			if (i == 0) begin
				sh_next[i] = NBKT + 1; sh_prev[i] = NIL;
			end else if (i <= NBKT) begin
				sh_next[i] = NIL; sh_prev[i] = NIL;
			end else begin
				sh_prev[i] = (i == NBKT + 1) ? 0 : i - 1;
				sh_next[i] = (i + 1 < NBLK) ? i + 1 : NIL;
			end
		end
	endfunction

	// Apply one request to the shadow store and return its response
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int bkt, head, pos, cur, fresh, after, p, n, f;
		bit hit;
		bkt = digit_fold_bucket(r.key);
		head = bkt + 1;
		pos = 0; hit = 0; cur = head;
		for (int s = 0; s < NBLK; s++) begin
			if (cur >= NBLK) break;
			pos = cur;
			if (sh_act[cur] && sh_key[cur] == r.key) begin
				hit = 1; break;
			end
			cur = sh_next[cur];
		end
		o.status = STAT_MISS;
		o.payload_out = '0;
		case (op_t'(r.operation))
			OP_FIND: if (hit) begin
				o.status = STAT_OK; o.payload_out = sh_pay[pos];
			end
			OP_INSERT: begin
				if (hit) begin
					o.status = STAT_DUP; o.payload_out = sh_pay[pos];
				end else begin
					fresh = sh_next[0];
					if (head >= NBLK || fresh == 0 || fresh >= NBLK) begin
						o.status = STAT_FULL;
					end else begin
						after = sh_next[fresh];
						if (after >= NBLK) after = NIL;
						sh_next[0] = after;
						if (after != NIL) sh_prev[after] = 0;
						sh_next[pos] = fresh;
						sh_prev[fresh] = pos;
						sh_next[fresh] = NIL;
						sh_key[fresh] = r.key;
						sh_pay[fresh] = r.payload;
						sh_act[fresh] = 1'b1;
						o.status = STAT_OK;
						o.payload_out = r.payload;
						pos = fresh;
					end
				end
			end
			OP_DELETE: if (hit) begin
				p = sh_prev[pos];
				n = sh_next[pos];
				if (n >= NBLK) n = NIL;
				if (p < NBLK) sh_next[p] = n;
				if (n != NIL) sh_prev[n] = p;
				f = sh_next[0];
				if (f >= NBLK) f = NIL;
				sh_next[pos] = f;
				if (f != NIL) sh_prev[f] = pos;
				sh_next[0] = pos;
				sh_prev[pos] = 0;
				sh_act[pos] = 1'b0;
				o.status = STAT_OK;
				o.payload_out = sh_pay[pos];
			end
			default: if (hit) begin
				sh_pay[pos] = r.payload;
				o.status = STAT_OK;
				o.payload_out = r.payload;
			end
		endcase
		o.position = pos[5:0];
		o.bucket = bkt[2:0];
		return o;
	endfunction

	function automatic logic [PAY_W-1:0] rand_payload();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic req_t mk_req(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
		req_t r;
		r.operation = op; r.key = key; r.payload = pay;
		return r;
	endfunction

	// Stimulus
	initial begin
		req_t r;
		n_err = 0;
		stim_done = 0;
		reset_store();
		for (int i = 0; i < 24; i++) key_pool[i] = (i < 4) ? KEY_W'(i) : KEY_W'($urandom());
		key_pool[4] = 31'h7FFF_FFFF;
		key_pool[5] = 31'd1234567890;
		// Directed: extremes, every operation, duplicates, misses
		pending_reqs.push_back(mk_req(OP_FIND, '0, '0));
		pending_reqs.push_back(mk_req(OP_INSERT, '0, '1));
		pending_reqs.push_back(mk_req(OP_INSERT, '0, 64'h5));
		pending_reqs.push_back(mk_req(OP_FIND, '0, '0));
		pending_reqs.push_back(mk_req(OP_INSERT, 31'h7FFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0));
		pending_reqs.push_back(mk_req(OP_REPLACE, 31'h7FFF_FFFF, 64'h5A5A_A5A5_F0F0_0F0F));
		pending_reqs.push_back(mk_req(OP_FIND, 31'h7FFF_FFFF, '0));
		pending_reqs.push_back(mk_req(OP_REPLACE, 31'd99, '1));
		pending_reqs.push_back(mk_req(OP_DELETE, 31'd99, '0));
		pending_reqs.push_back(mk_req(OP_INSERT, 31'd7, 64'd7));
		pending_reqs.push_back(mk_req(OP_INSERT, 31'd14, 64'd14));
		pending_reqs.push_back(mk_req(OP_DELETE, '0, '0));
		pending_reqs.push_back(mk_req(OP_DELETE, 31'h7FFF_FFFF, '0));
		pending_reqs.push_back(mk_req(OP_FIND, '0, '0));
		pending_reqs.push_back(mk_req(OP_DELETE, 31'd7, '0));
		pending_reqs.push_back(mk_req(OP_DELETE, 31'd14, '0));
		// Fill the store until full, then delete every second fill key
		for (int i = 0; i < 62; i++)
			pending_reqs.push_back(mk_req(OP_INSERT, KEY_W'(1000 + i), rand_payload()));
		for (int i = 0; i < 62; i += 2)
			pending_reqs.push_back(mk_req(OP_DELETE, KEY_W'(1000 + i), '0));
		// Random mix on a colliding key pool
		for (int i = 0; i < 1190; i++) begin
			r.operation = op_t'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) r.key = KEY_W'($urandom());
			else if ($urandom_range(0, 1)) r.key = key_pool[$urandom_range(0, 23)];
			else r.key = KEY_W'(1000 + $urandom_range(0, 70));
			r.payload = rand_payload();
			pending_reqs.push_back(r);
		end
		stim_done = 1;
	end

	// Driver: bursts with random gaps
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	int gap_left;
	int burst_left;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(apply_request(req));
			end
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && stim_done) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end else begin
			gap_left <= 0;
			burst_left <= 0;
		end
	end

	// Receiver stall pattern and response checking
	logic [7:0] stall_lfsr;
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			stall_lfsr <= 8'hB7;
			rsp_ready <= 1'b0;
		end else begin
			stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
			rsp_ready <= (cycles[12:10] == 3'd0) ? 1'b1 : (stall_lfsr[2:0] != 3'd0);
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %p", $time, rsp);
					n_err++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status)
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					if (rsp.payload_out !== want.payload_out)
						$display("%0t: payload_out expected %h actual %h",
							$time, want.payload_out, rsp.payload_out);
					if (rsp.position !== want.position)
						$display("%0t: position expected %0d actual %0d",
							$time, want.position, rsp.position);
					if (rsp.bucket !== want.bucket)
						$display("%0t: bucket expected %0d actual %0d",
							$time, want.bucket, rsp.bucket);
					if (rsp !== want) n_err++;
				end
			end
		end
	end

	// End of run and watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
			if (stim_done && arst_n && pending_reqs.size() == 0 && !req_valid
				&& expected_rsps.size() == 0) begin
				repeat (200) @(posedge clk);
				if (n_err == 0 && expected_rsps.size() == 0 && !rsp_valid) begin
					$display("tb: clean");
				end else begin
					$display("tb: errors");
				end
				$finish;
			end
		end
	end

endmodule

FILE: files.f
rtl/coht_pkg.sv
rtl/coht_ram.sv
rtl/coht_fold.sv
rtl/chained_overflow_hash_table.sv
sim/tb.sv
